/* rtl/ulact_pkg.sv */
// Shared types, constants and the wait table for the contention timer.
package ulact_pkg;

   localparam int TICK_W = 17;
   localparam int ADDR_W = 16;
   localparam int HOLD_W = 4;
   localparam int ADDED_W = 7;
   localparam int AMT_W = 5;
   localparam int WAIT_W = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TICK_W-1:0] TICK_MAX = 17'h1FFFF;
   localparam logic [TICK_W-1:0] FRAME_LEN_RESET = 17'd69888;
   localparam logic [ADDED_W-1:0] ADDED_MAX = 7'd127;

   localparam logic [ADDR_W-1:0] CONT_MASK = 16'hC000;
   localparam logic [ADDR_W-1:0] CONT_BASE = 16'h4000;

   localparam int CONT_FIRST_LINE = 64;
   localparam int CONT_LAST_LINE = 255;
   localparam int CONT_COLS = 128;

   // register indexes, taken from paddr[2]
   localparam logic CSR_FRAME_LENGTH = 1'b0;
   localparam logic CSR_IO_CONTENTION = 1'b1;

   typedef enum logic [2:0] {
      OP_FETCH = 3'd0,
      OP_READ = 3'd1,
      OP_WRITE = 3'd2,
      OP_IO_IN = 3'd3,
      OP_IO_OUT = 3'd4,
      OP_HOLD = 3'd5,
      OP_INTR = 3'd6,
      OP_NONE = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      CHG_ZERO = 3'd0,
      CHG_ONE = 3'd1,
      CHG_THREE = 3'd2,
      CHG_FOUR = 3'd3,
      CHG_HOLD = 3'd4,
      CHG_RAW = 3'd5
   } charge_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_FIRST = 7'b0000010,
      ST_IO_LATE = 7'b0000100,
      ST_IO_TRIPLE = 7'b0001000,
      ST_HOLD = 7'b0010000,
      ST_EMIT = 7'b0100000,
      ST_SPARE = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;
      logic charge;
      charge_type kind;
      logic use_wait;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic contended;
      logic port_lsb;
      logic [HOLD_W-1:0] hold_n;
   } dp_status_type;

   function automatic logic [WAIT_W-1:0] wait_lookup(input logic [2:0] phase);
      logic [WAIT_W-1:0] w;
      unique case (phase)
         3'd0: w = 3'd6;
         3'd1: w = 3'd5;
         3'd2: w = 3'd4;
         3'd3: w = 3'd3;
         3'd4: w = 3'd2;
         3'd5: w = 3'd1;
         default: w = 3'd0;
      endcase
      return w;
   endfunction

endpackage

/* rtl/ulact_csr.sv */
// Configuration registers behind the APB-style port.
module ulact_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ulact_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [ulact_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [ulact_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                  pready,
   output logic [ulact_pkg::TICK_W-1:0]          frame_length,
   output logic                                  io_on
);
   import ulact_pkg::*;

   logic [TICK_W-1:0] frame_length_ff, frame_length_in;
   logic              io_on_ff, io_on_in;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en = psel && penable && pwrite;

   always_comb begin
      frame_length_in = frame_length_ff;
      io_on_in = io_on_ff;
      if (wr_en) begin
         unique case (paddr[2])
            CSR_FRAME_LENGTH: frame_length_in = pwdata[TICK_W-1:0];
            CSR_IO_CONTENTION: io_on_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_FRAME_LENGTH: prdata = CSR_DATA_W'(frame_length_ff);
         CSR_IO_CONTENTION: prdata = CSR_DATA_W'(io_on_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= FRAME_LEN_RESET;
         io_on_ff <= 1'b0;
      end else begin
         frame_length_ff <= frame_length_in;
         io_on_ff <= io_on_in;
      end
   end

   assign frame_length = frame_length_ff;
   assign io_on = io_on_ff;

endmodule

/* rtl/ulact_dp.sv */
// Datapath: frame counter with line/column tracking, charge adder, result register.
module ulact_dp #(
   parameter int LINE_CYCLES = 224,
   parameter int MAX_HOLD = 15
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ulact_pkg::dp_cmd_type              cmd,
   output ulact_pkg::dp_status_type           status,
   input  logic [2:0]                         req_op,
   input  logic [ulact_pkg::ADDR_W-1:0]       req_address,
   input  logic [ulact_pkg::HOLD_W-1:0]       req_hold_count,
   input  logic                               req_start_frame,
   input  logic [ulact_pkg::TICK_W-1:0]       frame_length,
   output logic [ulact_pkg::ADDED_W-1:0]      rsp_added_cycles,
   output logic [ulact_pkg::TICK_W-1:0]       rsp_frame_position,
   output logic                               rsp_frame_done
);
   import ulact_pkg::*;

   localparam int COL_W = $clog2(LINE_CYCLES);
   localparam int COL_SUM_W = COL_W + 1;
   localparam int SAT_ROW = (int'(TICK_MAX) + 1) / LINE_CYCLES;
   localparam int SAT_COL = (int'(TICK_MAX) + 1) % LINE_CYCLES;
   localparam int ROW_W = $clog2(SAT_ROW + 1);

   op_type                op_ff, op_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [HOLD_W-1:0]     hold_ff, hold_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ADDED_W-1:0]    charged_ff, charged_in;
   logic [ADDED_W-1:0]    added_ff, added_in;
   logic [TICK_W-1:0]     pos_ff, pos_in;
   logic                  done_ff, done_in;

   logic [HOLD_W-1:0]     hold_n;
   logic                  in_window;
   logic [WAIT_W-1:0]     wait_val;
   logic [AMT_W-1:0]      base;
   logic [AMT_W-1:0]      amount;
   logic [TICK_W:0]       tick_sum;
   logic [COL_SUM_W-1:0]  col_sum;
   logic [ADDED_W:0]      charged_sum;

   assign hold_n = (int'(hold_ff) > MAX_HOLD) ? HOLD_W'(MAX_HOLD) : hold_ff;

   assign status.op = op_ff;
   assign status.contended = (addr_ff & CONT_MASK) == CONT_BASE;
   assign status.port_lsb = addr_ff[0];
   assign status.hold_n = hold_n;

   // row/col track tick + 1, so the wait is looked up one T-state ahead
   assign in_window = (row_ff >= ROW_W'(CONT_FIRST_LINE))
                   && (row_ff <= ROW_W'(CONT_LAST_LINE))
                   && (int'(col_ff) < CONT_COLS);
   assign wait_val = in_window ? wait_lookup(col_ff[2:0]) : '0;

   always_comb begin
      unique case (cmd.kind)
         CHG_ONE: base = AMT_W'(1);
         CHG_THREE: base = AMT_W'(3);
         CHG_FOUR: base = AMT_W'(4);
         CHG_HOLD: base = AMT_W'(hold_n);
         CHG_RAW: base = AMT_W'(hold_ff);
         default: base = '0;
      endcase
   end

   assign amount = base + (cmd.use_wait ? AMT_W'(wait_val) : AMT_W'(0));
   assign tick_sum = {1'b0, tick_ff} + (TICK_W+1)'(amount);
   assign col_sum = {1'b0, col_ff} + COL_SUM_W'(amount);
   assign charged_sum = {1'b0, charged_ff} + (ADDED_W+1)'(amount);

   always_comb begin
      op_in = op_ff;
      addr_in = addr_ff;
      hold_in = hold_ff;
      tick_in = tick_ff;
      row_in = row_ff;
      col_in = col_ff;
      charged_in = charged_ff;
      added_in = added_ff;
      pos_in = pos_ff;
      done_in = done_ff;
      if (cmd.load) begin
         op_in = op_type'(req_op);
         addr_in = req_address;
         hold_in = req_hold_count;
         charged_in = '0;
         if (req_start_frame) begin
            tick_in = '0;
            row_in = '0;
            col_in = COL_W'(1);
         end
      end
      if (cmd.charge) begin
         charged_in = (charged_sum > (ADDED_W+1)'(ADDED_MAX)) ? ADDED_MAX
                                                            : charged_sum[ADDED_W-1:0];
         if (tick_sum > (TICK_W+1)'(TICK_MAX)) begin
            tick_in = TICK_MAX;
            row_in = ROW_W'(SAT_ROW);
            col_in = COL_W'(SAT_COL);
         end else begin
            tick_in = tick_sum[TICK_W-1:0];
            if (col_sum >= COL_SUM_W'(LINE_CYCLES)) begin
               col_in = COL_W'(col_sum - COL_SUM_W'(LINE_CYCLES));
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_sum[COL_W-1:0];
            end
         end
      end
      if (cmd.emit) begin
         added_in = charged_ff;
         pos_in = tick_ff;
         done_in = tick_ff >= frame_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         row_ff <= '0;
         col_ff <= COL_W'(1);
      end else begin
         tick_ff <= tick_in;
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      addr_ff <= addr_in;
      hold_ff <= hold_in;
      charged_ff <= charged_in;
      added_ff <= added_in;
      pos_ff <= pos_in;
      done_ff <= done_in;
   end

   assign rsp_added_cycles = added_ff;
   assign rsp_frame_position = pos_ff;
   assign rsp_frame_done = done_ff;

endmodule

/* rtl/ulact_ctrl.sv */
// Controller: sequences the charge steps of one request and owns the handshakes.
module ulact_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           io_on,
   input  ulact_pkg::dp_status_type       status,
   output ulact_pkg::dp_cmd_type          cmd
);
   import ulact_pkg::*;

   state_type          state_ff, state_in;
   logic [HOLD_W-1:0]  count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            state_in = ST_EMIT;
            count_in = '0;
            unique case (status.op)
               OP_FETCH: begin
                  cmd.charge = 1'b1;
                  cmd.kind = CHG_FOUR;
                  cmd.use_wait = status.contended;
               end
               OP_READ, OP_WRITE: begin
                  cmd.charge = 1'b1;
                  cmd.kind = CHG_THREE;
                  cmd.use_wait = status.contended;
               end
               OP_IO_IN, OP_IO_OUT: begin
                  cmd.charge = 1'b1;
                  if (io_on) begin
                     cmd.kind = CHG_ONE;
                     cmd.use_wait = status.contended;
                     if (status.port_lsb && status.contended) begin
                        state_in = ST_IO_TRIPLE;
                     end else begin
                        state_in = ST_IO_LATE;
                     end
                  end else begin
                     cmd.kind = CHG_FOUR;
                  end
               end
               OP_HOLD: begin
                  if (status.contended) begin
                     cmd.charge = status.hold_n != '0;
                     cmd.kind = CHG_ONE;
                     cmd.use_wait = 1'b1;
                     count_in = HOLD_W'(1);
                     if (status.hold_n > HOLD_W'(1)) begin
                        state_in = ST_HOLD;
                     end
                  end else begin
                     cmd.charge = 1'b1;
                     cmd.kind = CHG_HOLD;
                  end
               end
               OP_INTR: begin
                  cmd.charge = 1'b1;
                  cmd.kind = CHG_RAW;
               end
               default: ;
            endcase
         end
         ST_IO_LATE: begin
            cmd.charge = 1'b1;
            cmd.kind = CHG_THREE;
            cmd.use_wait = !status.port_lsb;
            state_in = ST_EMIT;
         end
         ST_IO_TRIPLE: begin
            cmd.charge = 1'b1;
            cmd.kind = CHG_ONE;
            cmd.use_wait = 1'b1;
            count_in = count_ff + HOLD_W'(1);
            if (count_ff == HOLD_W'(2)) begin
               state_in = ST_EMIT;
            end
         end
         ST_HOLD: begin
            cmd.charge = 1'b1;
            cmd.kind = CHG_ONE;
            cmd.use_wait = 1'b1;
            count_in = count_ff + HOLD_W'(1);
            if (HOLD_W'(count_ff + HOLD_W'(1)) == status.hold_n) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/ula_memory_io_contention_timer_core.sv */
// Top level of the bus-access timer with video contention.
// Steps: a single charge for most requests (flat I/O too), early and late charges for a
// patterned I/O access, one charge per hold step for a contended hold.
// Requests: one at a time; the next is taken once the result is registered, which waits
// while an earlier result is still stalled.
// Reset (synchronous): counter to zero, frame length 69888, I/O pattern off, idle.
module ula_memory_io_contention_timer_core #(
   parameter int LINE_CYCLES = 224,
   parameter int MAX_HOLD = 15
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_op,
   input  logic [ulact_pkg::ADDR_W-1:0]         req_address,
   input  logic [ulact_pkg::HOLD_W-1:0]         req_hold_count,
   input  logic                                 req_start_frame,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ulact_pkg::ADDED_W-1:0]        rsp_added_cycles,
   output logic [ulact_pkg::TICK_W-1:0]         rsp_frame_position,
   output logic                                 rsp_frame_done,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ulact_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ulact_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ulact_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                 pready
);
   import ulact_pkg::*;

   logic [TICK_W-1:0]  frame_length;
   logic               io_on;
   dp_cmd_type         cmd;
   dp_status_type      status;

   // Registers: frame length for the done flag, I/O pattern enable for the sequencer.
   ulact_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .frame_length (frame_length),
      .io_on        (io_on)
   );

   // Sequencer: one charge step per cycle. A request is latched, optionally clears
   // the frame counter, then walks through its early/late or hold steps, and the
   // total is pushed into the result register once that register is free.
   ulact_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .io_on     (io_on),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: keeps the T-state counter plus a line/column pair for the next
   // T-state, so the contention wait comes from a compare and an 8-entry table
   // instead of a division. Each charge adds into counter, column and total.
   ulact_dp #(
      .LINE_CYCLES (LINE_CYCLES),
      .MAX_HOLD    (MAX_HOLD)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_address        (req_address),
      .req_hold_count     (req_hold_count),
      .req_start_frame    (req_start_frame),
      .frame_length       (frame_length),
      .rsp_added_cycles   (rsp_added_cycles),
      .rsp_frame_position (rsp_frame_position),
      .rsp_frame_done     (rsp_frame_done)
   );

endmodule

/* rtl/ulact_checker.sv */
// Port-level checks for the contention timer, bound to the top level.
module ulact_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [2:0]                           req_op,
   input logic [ulact_pkg::ADDR_W-1:0]         req_address,
   input logic [ulact_pkg::HOLD_W-1:0]         req_hold_count,
   input logic                                 req_start_frame,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [ulact_pkg::ADDED_W-1:0]        rsp_added_cycles,
   input logic [ulact_pkg::TICK_W-1:0]         rsp_frame_position,
   input logic                                 rsp_frame_done,
   input logic                                 psel,
   input logic                                 penable,
   input logic                                 pwrite,
   input logic [ulact_pkg::CSR_ADDR_W-1:0]     paddr,
   input logic [ulact_pkg::CSR_DATA_W-1:0]     pwdata,
   input logic [ulact_pkg::CSR_DATA_W-1:0]     prdata,
   input logic                                 pready
);
   import ulact_pkg::*;

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_added_cycles)
         && $stable(rsp_frame_position) && $stable(rsp_frame_done))
      else $error("result changed while stalled");

   // an accepted request keeps the block busy the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken without going busy");

   // a new result only appears after the block was busy with a request
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a request in flight");

   // reset leaves no result pending and the block ready
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind ula_memory_io_contention_timer_core ulact_checker u_ulact_checker (.*);

/* tb/contention_sb_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard class: predicts the timing of each request and checks the results against it.
package contention_sb_pkg;
   import ulact_pkg::*;

   localparam int LINE_LEN = 224;
   localparam int HOLD_LIMIT = 15;

   typedef struct {
      logic [ADDED_W-1:0] added;
      logic [TICK_W-1:0] position;
      logic done;
   } access_timing_type;

   class frame_timer_scoreboard;
      logic [TICK_W-1:0] ticks;
      logic [TICK_W-1:0] frame_len;
      logic io_pattern_on;
      int unsigned spent;
      access_timing_type expected_timings[$];
      int mismatches;

      function new();
         ticks = '0;
         frame_len = FRAME_LEN_RESET;
         io_pattern_on = 1'b0;
         spent = 0;
         mismatches = 0;
      endfunction

      function void write_register(logic index, logic [CSR_DATA_W-1:0] value);
         if (index == CSR_FRAME_LENGTH) begin
            frame_len = value[TICK_W-1:0];
         end else begin
            io_pattern_on = value[0];
         end
      endfunction

      function int unsigned pending();
         return expected_timings.size();
      endfunction

      // wait is looked up one T-state ahead of the current count
      function int unsigned ula_wait();
         int unsigned p;
         int unsigned line;
         int unsigned col;
         p = ticks;
         p = p + 1;
         line = p / LINE_LEN;
         col = p % LINE_LEN;
         if (line < CONT_FIRST_LINE || line > CONT_LAST_LINE || col >= CONT_COLS) return 0;
         return ((col & 7) < 6) ? 6 - (col & 7) : 0;
      endfunction

      function void charge(int unsigned n);
         int unsigned t;
         t = ticks;
         t = t + n;
         ticks = (t > TICK_MAX) ? TICK_MAX : t[TICK_W-1:0];
         spent += n;
      endfunction

      function bit is_contended(logic [ADDR_W-1:0] a);
         return (a & CONT_MASK) == CONT_BASE;
      endfunction

      function void note_request(op_type op, logic [ADDR_W-1:0] addr,
                                 logic [HOLD_W-1:0] hold, logic start);
         access_timing_type r;
         int unsigned n;
         bit cont;
         cont = is_contended(addr);
         if (start) ticks = '0;
         spent = 0;
         case (op)
            OP_FETCH: charge(cont ? ula_wait() + 4 : 4);
            OP_READ, OP_WRITE: charge(cont ? ula_wait() + 3 : 3);
            OP_IO_IN, OP_IO_OUT: begin
               if (!io_pattern_on) begin
                  charge(4);
               end else begin
                  charge(cont ? ula_wait() + 1 : 1);
                  if (!addr[0]) begin
                     charge(ula_wait() + 3);
                  end else if (cont) begin
                     repeat (3) charge(ula_wait() + 1);
                  end else begin
                     charge(3);
                  end
               end
            end
            OP_HOLD: begin
               n = (hold > HOLD_LIMIT) ? HOLD_LIMIT : hold;
               if (cont) begin
                  repeat (n) charge(ula_wait() + 1);
               end else begin
                  charge(n);
               end
            end
            OP_INTR: charge(hold);
            default: ;
         endcase
         r.added = (spent > ADDED_MAX) ? ADDED_MAX : spent[ADDED_W-1:0];
         r.position = ticks;
         r.done = (ticks >= frame_len);
         expected_timings.push_back(r);
      endfunction

      function void check_result(logic [ADDED_W-1:0] added, logic [TICK_W-1:0] position,
                                 logic done);
         access_timing_type r;
         if (expected_timings.size() == 0) begin
            $error("result with no request outstanding: added_cycles %0d frame_position %0d",
                   added, position);
            mismatches++;
            return;
         end
         r = expected_timings.pop_front();
         if (added !== r.added) begin
            $error("added_cycles: expected %0d, got %0d", r.added, added);
            mismatches++;
         end
         if (position !== r.position) begin
            $error("frame_position: expected %0d, got %0d", r.position, position);
            mismatches++;
         end
         if (done !== r.done) begin
            $error("frame_done: expected %0d, got %0d", r.done, done);
            mismatches++;
         end
      endfunction
   endclass

endpackage

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Top-level testbench for the contention timer: clock, reset, request and CSR drivers.
module testbench;
   import ulact_pkg::*;
   import contention_sb_pkg::*;

   // hard stop, far beyond the slowest correct run
   localparam int CYCLE_LIMIT = 5_000_000;

   logic clock = 1'b0;
   logic reset;

   logic req_valid;
   logic req_stall;
   logic [2:0] req_op;
   logic [ADDR_W-1:0] req_address;
   logic [HOLD_W-1:0] req_hold_count;
   logic req_start_frame;

   logic rsp_valid;
   logic rsp_stall;
   logic [ADDED_W-1:0] rsp_added_cycles;
   logic [TICK_W-1:0] rsp_frame_position;
   logic rsp_frame_done;

   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   frame_timer_scoreboard sb = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_hold_cycles = 0;
   int cycle_count = 0;

   ula_memory_io_contention_timer_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_address        (req_address),
      .req_hold_count     (req_hold_count),
      .req_start_frame    (req_start_frame),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_added_cycles   (rsp_added_cycles),
      .rsp_frame_position (rsp_frame_position),
      .rsp_frame_done     (rsp_frame_done),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #5 clock = ~clock;

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL ula_memory_io_contention_timer_core");
         $finish;
      end
   end

   // Result side: stall at random, or hold off for a long stretch when asked.
   // Stall changes only at the falling edge so the block sees a settled value.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_hold_cycles > 0) begin
            rsp_stall = 1'b1;
            stall_hold_cycles--;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // Check every result taken at a rising edge against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         sb.check_result(rsp_added_cycles, rsp_frame_position, rsp_frame_done);
      end
   end

   // Offer one request; idle first at random, then hold it until accepted.
   // Valid stays high after acceptance until the next falling edge decides.
   task automatic send_request(input op_type op, input logic [ADDR_W-1:0] addr,
                               input logic [HOLD_W-1:0] hold, input logic start);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_op = op;
      req_address = addr;
      req_hold_count = hold;
      req_start_frame = start;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, addr, hold, start);
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the write at the
   // edge where pready is seen high.
   task automatic csr_write(input logic index, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {index, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_register(index, value);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // Send n_real random requests while walking the frame counter toward
   // sweep_end; restart clears the counter on the first one. Contention only
   // shows deep in the frame, so interrupt-time requests carry the counter
   // forward between the random ones. A sweep_end of zero keeps the counter
   // where the last phase left it.
   task automatic run_phase(input int n_real, input int sweep_end, input bit restart,
                            input int pause_at, input int hold_off_at);
      int target;
      int gap;
      logic [ADDR_W-1:0] addr;
      for (int i = 0; i < n_real; i++) begin
         target = (i * sweep_end) / n_real + $urandom_range(0, LINE_LEN - 1);
         if (i > 0 && $urandom_range(0, 1) == 1) begin
            while (int'(sb.ticks) < target && sb.ticks != TICK_MAX) begin
               gap = target - int'(sb.ticks);
               send_request(OP_INTR, ADDR_W'($urandom),
                            (gap > HOLD_LIMIT) ? HOLD_W'(HOLD_LIMIT) : HOLD_W'(gap), 1'b0);
            end
         end
         // pause the sender until the block has nothing outstanding
         if (i == pause_at) drain();
         // starve the result side so the block backs up into the request side
         if (i == hold_off_at) stall_hold_cycles = 300;
         if ($urandom_range(0, 1) == 1) begin
            addr = CONT_BASE | ADDR_W'($urandom_range(0, 16383));
         end else begin
            addr = ADDR_W'($urandom);
         end
         send_request(op_type'($urandom_range(0, 7)), addr,
                      HOLD_W'($urandom_range(0, 15)), restart && (i == 0));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_FETCH;
      req_address = '0;
      req_hold_count = '0;
      req_start_frame = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, flat I/O and a zero frame length: frame done on every request.
      csr_write(CSR_FRAME_LENGTH, 32'd0);
      csr_write(CSR_IO_CONTENTION, 32'd0);
      send_request(OP_FETCH, 16'h0000, 4'd0, 1'b0);
      send_request(OP_READ, 16'hFFFF, 4'd15, 1'b0);
      send_request(OP_WRITE, 16'h4000, 4'd0, 1'b0);
      send_request(OP_IO_IN, 16'hFFFF, 4'd0, 1'b0);
      send_request(OP_IO_OUT, 16'h0000, 4'd0, 1'b0);
      send_request(OP_HOLD, 16'h4000, 4'd15, 1'b0);
      send_request(OP_HOLD, 16'h8000, 4'd0, 1'b0);
      send_request(OP_INTR, 16'h0000, 4'd15, 1'b0);
      send_request(OP_INTR, 16'hFFFF, 4'd0, 1'b0);
      send_request(OP_NONE, 16'h7FFF, 4'd15, 1'b1);
      send_request(OP_FETCH, 16'h7FFF, 4'd0, 1'b1);

      // Directed, port pattern on and a frame length of one.
      drain();
      csr_write(CSR_FRAME_LENGTH, 32'd1);
      csr_write(CSR_IO_CONTENTION, 32'd1);
      send_request(OP_INTR, 16'h0000, 4'd0, 1'b1);
      send_request(OP_INTR, 16'h0000, 4'd1, 1'b0);
      send_request(OP_IO_IN, 16'h4000, 4'd0, 1'b0);
      send_request(OP_IO_IN, 16'h4001, 4'd0, 1'b0);
      send_request(OP_IO_OUT, 16'h0001, 4'd0, 1'b0);
      send_request(OP_IO_OUT, 16'hFFFE, 4'd0, 1'b0);
      send_request(OP_IO_IN, 16'h7FFF, 4'd0, 1'b0);
      send_request(OP_HOLD, 16'h7FFF, 4'd0, 1'b0);
      send_request(OP_NONE, 16'h0000, 4'd0, 1'b1);

      // Random, sender mostly busy, receiver mostly stalled; walk up to the
      // first contended line.
      drain();
      csr_write(CSR_FRAME_LENGTH, 32'd69888);
      csr_write(CSR_IO_CONTENTION, 32'd1);
      send_idle_pct = 9;
      recv_idle_pct = 87;
      run_phase(60, 14400, 1'b1, -1, -1);

      // Random, roles swapped, flat I/O; stay on the contended lines.
      drain();
      csr_write(CSR_FRAME_LENGTH, 32'd70912);
      csr_write(CSR_IO_CONTENTION, 32'd0);
      send_idle_pct = 87;
      recv_idle_pct = 9;
      run_phase(80, 0, 1'b0, 40, -1);

      // Random, no idling; the frame ends partway through so frame done flips.
      drain();
      csr_write(CSR_FRAME_LENGTH, CSR_DATA_W'(sb.ticks) + 32'd300);
      csr_write(CSR_IO_CONTENTION, 32'd1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(80, 0, 1'b0, -1, 30);

      drain();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS ula_memory_io_contention_timer_core");
      end else begin
         $display("FAIL ula_memory_io_contention_timer_core");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/ulact_pkg.sv
rtl/ulact_csr.sv
rtl/ulact_dp.sv
rtl/ulact_ctrl.sv
rtl/ula_memory_io_contention_timer_core.sv
rtl/ulact_checker.sv
tb/contention_sb_pkg.sv
tb/testbench.sv
